@@ src/vwsbp_pkg.sv @@
`timescale 1ns / 1ps

package vwsbp_pkg;

  // Field and register widths
  localparam int SampleWidth   = 16;
  localparam int ByteWidth     = 8;
  localparam int WselWidth     = 2;
  localparam int ResBitsWidth  = 7;
  localparam int ResCntWidth   = 3;
  localparam int BufWidth      = 24;
  localparam int TotalWidth    = 5;
  localparam int MaxBytes      = 3;
  localparam int ByteCntWidth  = 2;
  localparam int ApbDataWidth  = 32;
  localparam int ApbAddrWidth  = 3;

  // Register map
  localparam logic [ApbAddrWidth-1:0] AddrWidthSelect = 3'd0;

  // Width select codes
  localparam logic [WselWidth-1:0] WselBits12 = 2'd0;
  localparam logic [WselWidth-1:0] WselBits10 = 2'd1;
  localparam logic [WselWidth-1:0] WselBits8  = 2'd2;
  localparam logic [WselWidth-1:0] WselBits6  = 2'd3;

  // Packed bytes and next residual for one sample
  typedef struct packed {
    logic [MaxBytes-1:0][ByteWidth-1:0] bytes;
    logic [ByteCntWidth-1:0]            count;
    logic                               last;
    logic [ResBitsWidth-1:0]            res_bits;
    logic [ResCntWidth-1:0]             res_cnt;
  } pack_result_t;

  // Sample width in bits for a width select code
  function automatic logic [TotalWidth-1:0] sample_bits(input logic [WselWidth-1:0] wsel);
    logic [TotalWidth-1:0] w;
    case (wsel)
      WselBits12: w = 5'd12;
      WselBits10: w = 5'd10;
      WselBits8:  w = 5'd8;
      WselBits6:  w = 5'd6;
      default:    w = 5'd12;
    endcase
    return w;
  endfunction

endpackage

@@ src/vwsbp_pack.sv @@
`timescale 1ns / 1ps

module vwsbp_pack (
  input  logic [vwsbp_pkg::WselWidth-1:0]    width_select,
  input  logic [vwsbp_pkg::SampleWidth-1:0]  sample,
  input  logic                               last_sample,
  input  logic [vwsbp_pkg::ResBitsWidth-1:0] residual_bits,
  input  logic [vwsbp_pkg::ResCntWidth-1:0]  residual_count,
  output vwsbp_pkg::pack_result_t            result
);
  import vwsbp_pkg::*;

  logic [TotalWidth-1:0]  w;
  logic [SampleWidth-1:0] mask;
  logic [BufWidth-1:0]    sbuf;
  logic [TotalWidth-1:0]  total;
  logic [1:0]             nfull;
  logic [2:0]             rem;

  // Mask the sample and place it above the held bits
  always_comb begin
    w     = sample_bits(width_select);
    mask  = SampleWidth'((17'd1 << w) - 17'd1);
    sbuf  = {{(BufWidth-ResBitsWidth){1'b0}}, residual_bits} |
            (BufWidth'(sample & mask) << residual_count);
    total = TotalWidth'(residual_count) + w;
    nfull = total[4:3];
    rem   = total[2:0];
  end

  // Split into bytes, count them and form the next residual
  always_comb begin
    result.bytes[0] = sbuf[7:0];
    result.bytes[1] = sbuf[15:8];
    result.bytes[2] = sbuf[23:16];
    result.last     = last_sample;
    if (last_sample) begin
      result.count    = nfull + ByteCntWidth'(rem != 3'd0);
      result.res_bits = '0;
      result.res_cnt  = '0;
    end else begin
      result.count    = nfull;
      result.res_cnt  = rem;
      case (nfull)
        2'd0:    result.res_bits = sbuf[6:0];
        2'd1:    result.res_bits = sbuf[14:8];
        2'd2:    result.res_bits = sbuf[22:16];
        default: result.res_bits = '0;
      endcase
    end
  end

endmodule

@@ src/variable_width_sample_bit_packer_top.sv @@
`timescale 1ns / 1ps

// Bit packer for converter samples, LSB first.
// Input stream (s_*): one sample per request; s_tdata carries the sample and
// s_tlast marks the last sample of a block. Output stream (m_*): one packed
// byte per request; m_tlast marks the final byte of a block.
// width_select (APB address 0) picks 12, 10, 8 or 6 bits per sample; write it
// only while no request is in flight.
// A sample is held in the input register, then moved into the output bank,
// from which its first byte is visible to the receiver.
// Throughput: the output register bank delivers one byte per cycle while
// the receiver is ready. A new sample is taken while bytes of the
// previous one still wait in the output bank.
// A stalled receiver holds the current byte; the input register then fills
// and s_tready drops until the output bank drains.
// Reset clears the residual bits, both stages and width_select (12 bits).
module variable_width_sample_bit_packer_top (
  input  logic                                clk,
  input  logic                                rst,
  // APB configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vwsbp_pkg::ApbAddrWidth-1:0]  paddr,
  input  logic [vwsbp_pkg::ApbDataWidth-1:0]  pwdata,
  output logic [vwsbp_pkg::ApbDataWidth-1:0]  prdata,
  output logic                                pready,
  // Sample stream in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [vwsbp_pkg::SampleWidth-1:0]   s_tdata,  // [15:0] sample
  input  logic                                s_tlast,  // last_sample
  // Byte stream out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [vwsbp_pkg::ByteWidth-1:0]     m_tdata,  // [7:0] packed_byte
  output logic                                m_tlast   // block_end
);
  import vwsbp_pkg::*;

  logic [WselWidth-1:0]    width_select;
  logic [ResBitsWidth-1:0] residual_bits;
  logic [ResCntWidth-1:0]  residual_count;

  logic                    in_valid;
  logic [SampleWidth-1:0]  in_sample;
  logic                    in_last;

  logic [MaxBytes-1:0][ByteWidth-1:0] res_bytes;
  logic [ByteCntWidth-1:0] res_cnt;
  logic [ByteCntWidth-1:0] res_idx;
  logic                    res_last;
  logic                    res_valid;

  pack_result_t            pr;
  logic                    res_done;
  logic                    res_free;
  logic                    move;
  logic                    cfg_write;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr == AddrWidthSelect) ?
                     {{(ApbDataWidth-WselWidth){1'b0}}, width_select} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_select <= WselBits12;
    end else if (cfg_write && paddr == AddrWidthSelect) begin
      width_select <= pwdata[WselWidth-1:0];
    end
  end

  // Pack the held sample against the residual
  vwsbp_pack u_pack (
    .width_select   (width_select),
    .sample         (in_sample),
    .last_sample    (in_last),
    .residual_bits  (residual_bits),
    .residual_count (residual_count),
    .result         (pr)
  );

  // Handshake control
  assign m_tvalid = res_valid;
  assign m_tdata  = res_bytes[res_idx];
  assign res_done = res_valid && m_tready && (res_idx == res_cnt - 2'd1);
  assign m_tlast  = res_last && (res_idx == res_cnt - 2'd1);
  assign res_free = !res_valid || res_done;
  assign move     = in_valid && res_free;
  assign s_tready = !in_valid || res_free;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_sample <= s_tdata;
      in_last   <= s_tlast;
    end
  end

  // Residual state and output byte bank
  always_ff @(posedge clk) begin
    if (rst) begin
      residual_bits  <= '0;
      residual_count <= '0;
      res_valid      <= 1'b0;
      res_idx        <= '0;
      res_cnt        <= '0;
      res_last       <= 1'b0;
    end else if (move) begin
      residual_bits  <= pr.res_bits;
      residual_count <= pr.res_cnt;
      res_valid      <= (pr.count != '0);
      res_idx        <= '0;
      res_cnt        <= pr.count;
      res_last       <= pr.last;
      res_bytes      <= pr.bytes;
    end else if (res_done) begin
      res_valid <= 1'b0;
    end else if (res_valid && m_tready) begin
      res_idx <= res_idx + 2'd1;
    end
  end

  // Checks
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_idx < res_cnt))
    else $error("byte index past byte count");

  a_bank_not_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_cnt != '0))
    else $error("output bank valid with no bytes");

  a_last_yields_byte: assert property (@(posedge clk) disable iff (rst)
    (move && in_last) |-> (pr.count != '0))
    else $error("last sample produced no byte");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (move && in_last) |=> (residual_count == '0 && residual_bits == '0))
    else $error("residual not cleared after last sample");

  a_stall_holds_byte: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !m_tready) |=> (res_valid && $stable(res_idx)))
    else $error("byte moved while receiver stalled");

endmodule

@@ tb/sv/variable_width_sample_bit_packer_top_tb.sv @@
`timescale 1ns / 1ps

module variable_width_sample_bit_packer_top_tb;
  import vwsbp_pkg::*;

  localparam int ClkHalf       = 10;
  localparam int ResetCycles   = 7;
  localparam int CycleLimit    = 400000;
  localparam int SettleCycles  = 8;
  localparam int TailCycles    = 20;
  localparam int HoldOffCycles = 300;
  localparam int RandomPhases  = 8;
  localparam int PhaseItems    = 44;

  // One expected output byte
  typedef struct packed {
    logic [ByteWidth-1:0] data;
    logic                 block_end;
  } out_byte_t;

  // Packing predictor and store of bytes still owed by the block
  class byte_board;
    out_byte_t               expected_bytes[$];
    logic [WselWidth-1:0]    wsel;
    logic [ResBitsWidth-1:0] held_bits;
    logic [ResCntWidth-1:0]  held_count;
    int                      errors;

    function new();
      wsel       = WselBits12;
      held_bits  = '0;
      held_count = '0;
      errors     = 0;
    endfunction

    function int unsigned bits_for(logic [WselWidth-1:0] sel);
      case (sel)
        WselBits12: return 12;
        WselBits10: return 10;
        WselBits8:  return 8;
        default:    return 6;
      endcase
    endfunction

    function void set_width(logic [WselWidth-1:0] sel);
      wsel = sel;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Append the masked sample above the held bits and emit every full byte
    function void note_sample(logic [SampleWidth-1:0] smp, logic last_smp);
      int unsigned           w;
      int unsigned           total;
      logic [SampleWidth-1:0] val;
      logic [BufWidth-1:0]   acc;
      out_byte_t             fresh[$];
      out_byte_t             item;
      w     = bits_for(wsel);
      val   = smp & ((SampleWidth'(1) << w) - SampleWidth'(1));
      acc   = BufWidth'(held_bits) | (BufWidth'(val) << held_count);
      total = held_count + w;
      while (total >= 8) begin
        item.data      = acc[ByteWidth-1:0];
        item.block_end = 1'b0;
        fresh.push_back(item);
        acc   = acc >> 8;
        total = total - 8;
      end
      if (last_smp) begin
        // flush leftover bits as a zero-padded byte
        if (total > 0) begin
          item.data      = acc[ByteWidth-1:0];
          item.block_end = 1'b0;
          fresh.push_back(item);
        end
        if (fresh.size() > 0) fresh[fresh.size()-1].block_end = 1'b1;
        held_bits  = '0;
        held_count = '0;
      end else begin
        held_bits  = acc[ResBitsWidth-1:0];
        held_count = total[ResCntWidth-1:0];
      end
      foreach (fresh[i]) expected_bytes.push_back(fresh[i]);
    endfunction

    task report(string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one accepted byte against the oldest expectation
    task check_byte(logic [ByteWidth-1:0] data, logic block_end);
      out_byte_t want;
      if (expected_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h tlast %0b", data, block_end));
      end else begin
        want = expected_bytes.pop_front();
        if (data !== want.data)
          report($sformatf("byte %02h, expected %02h", data, want.data));
        if (block_end !== want.block_end)
          report($sformatf("tlast %0b, expected %0b on byte %02h",
                           block_end, want.block_end, want.data));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [ApbAddrWidth-1:0] paddr;
  logic [ApbDataWidth-1:0] pwdata;
  logic [ApbDataWidth-1:0] prdata;
  logic                    pready;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [SampleWidth-1:0]  s_tdata;   // [15:0] sample
  logic                    s_tlast;   // last_sample
  logic                    m_tvalid;
  logic                    m_tready;
  logic [ByteWidth-1:0]    m_tdata;   // [7:0] packed_byte
  logic                    m_tlast;   // block_end

  byte_board board;
  int        cycle_count;
  bit        gaps_on;
  bit        hold_request;
  int        hold_left;
  int        stall_left;
  int        rx_mode_left;
  bit        rx_calm;

  variable_width_sample_bit_packer_top uut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial clk = 1'b0;
  always #(ClkHalf) clk = ~clk;

  // Abort a run that hangs
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("variable_width_sample_bit_packer_top_tb failed");
      $finish;
    end
  end

  // Check accepted bytes, then pick the next ready level
  initial begin
    hold_request = 1'b0;
    hold_left    = 0;
    stall_left   = 0;
    rx_mode_left = 0;
    rx_calm      = 1'b0;
  end

  always @(posedge clk) begin
    logic next_ready;
    if (!rst && m_tvalid && m_tready) board.check_byte(m_tdata, m_tlast);
    if (rx_mode_left == 0) begin
      rx_calm      = ($urandom_range(0, 3) == 0);
      rx_mode_left = $urandom_range(50, 150);
    end else begin
      rx_mode_left--;
    end
    if (hold_request) begin
      hold_left    = HoldOffCycles;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      next_ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      next_ready = 1'b0;
    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
      // mostly short stalls, now and then a long one
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(1, 3);
      stall_left--;
      next_ready = 1'b0;
    end else begin
      next_ready = 1'b1;
    end
    m_tready <= next_ready;
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offer one sample, hold it until taken, then maybe idle
  task send_sample(logic [SampleWidth-1:0] smp, logic last_smp);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tlast  <= last_smp;
    do @(posedge clk); while (!s_tready);
    board.note_sample(smp, last_smp);
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drain the block, then write width_select over APB
  task write_width(logic [WselWidth-1:0] sel);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrWidthSelect;
    pwdata  <= ApbDataWidth'(sel);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    board.set_width(sel);
  endtask

  function logic [SampleWidth-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 15) return '0;
    return SampleWidth'($urandom_range(0, 65535));
  endfunction

  initial begin
    logic [WselWidth-1:0] sel;
    board    = new();
    rst      = 1'b1;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    m_tready = 1'b0;
    gaps_on  = 1'b1;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // 12-bit: bits above the width, exact byte boundary, padded flush
    write_width(WselBits12);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hF123, 1'b1);
    send_sample(16'h0ABC, 1'b0);
    send_sample(16'h0FFF, 1'b1);

    // 6-bit: no full byte yet, exact end, one-sample block
    write_width(WselBits6);
    send_sample(16'hFFC0, 1'b0);
    send_sample(16'h003F, 1'b0);
    send_sample(16'h0015, 1'b0);
    send_sample(16'h002A, 1'b1);
    send_sample(16'h0001, 1'b1);
    send_sample(16'h1234, 1'b0);

    // change width while six bits are still held
    write_width(WselBits10);
    send_sample(16'h03FF, 1'b0);
    send_sample(16'hFC00, 1'b0);
    send_sample(16'h0155, 1'b1);

    write_width(WselBits8);
    send_sample(16'hFF00, 1'b0);
    send_sample(16'h00FF, 1'b0);
    send_sample(16'h8001, 1'b1);

    // random blocks under varying widths; one phase holds the receiver off
    for (int p = 0; p < RandomPhases; p++) begin
      case (p)
        0:       sel = WselBits12;
        1:       sel = WselBits6;
        2:       sel = WselBits10;
        3:       sel = WselBits8;
        default: sel = WselWidth'($urandom_range(0, 3));
      endcase
      write_width(sel);
      gaps_on = (p == 2) ? 1'b0 : ($urandom_range(0, 2) != 0);
      if (p == 2) hold_request = 1'b1;
      for (int i = 0; i < PhaseItems; i++)
        send_sample(pick_sample(), $urandom_range(0, 7) == 0);
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() > 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (board.errors == 0) begin
      $display("variable_width_sample_bit_packer_top_tb passed");
    end else begin
      $display("variable_width_sample_bit_packer_top_tb failed");
    end
    $finish;
  end

endmodule
